// ===== hdl/calendar_date_stepper_assert.svh =====
// assertion macros used by the date stepper state module
// each macro expects clk and rst in scope
`ifndef CALENDAR_DATE_STEPPER_ASSERT_SVH
`define CALENDAR_DATE_STEPPER_ASSERT_SVH

// condition implies consequence in the same cycle
`define CDS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date stepper check failed");

// condition implies consequence in the next cycle
`define CDS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date stepper check failed");

`endif

// ===== hdl/cds_pkg.sv =====
`timescale 1ns / 1ps

package cds_pkg;

  // command codes
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_NEXT = 2'd1;
  localparam logic [1:0] FUNC_PREV = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // month codes
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // iso weekday codes
  localparam logic [2:0] WD_MON = 3'd1;
  localparam logic [2:0] WD_SUN = 3'd7;

  // decoded load command handed from the decode pipeline to the state stage
  typedef struct packed {
    logic [1:0]  func;
    logic        date_ok;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [8:0]  year_mod400;
    logic [21:0] epoch;
    logic [2:0]  wd;
  } load_item_t;

  // days in a month of a common year, zero for codes that are no month
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
      4'd2:                                         n = 5'd28;
      default:                                      n = 5'd0;
    endcase
    return n;
  endfunction

  // days of a common year before the first of the month
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // reciprocal for a 14 bit divide by 100: q = (x * DIV100_MUL) >> DIV100_SHIFT
  localparam logic [13:0] DIV100_MUL   = 14'd10486;
  localparam int          DIV100_SHIFT = 20;

endpackage

// ===== hdl/cds_load_calc.sv =====
`timescale 1ns / 1ps

// six stage pipeline that turns a raw item into a checked date with its day number,
// weekday and year mod 400; steps pass through the same stages and use only their command
module cds_load_calc #(
  parameter int MIN_YEAR = 1800,
  parameter int MAX_YEAR = 9999
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_func,
  input  logic [4:0]          in_day,
  input  logic [3:0]          in_month,
  input  logic [13:0]         in_year,
  output logic                out_valid,
  input  logic                out_ready,
  output cds_pkg::load_item_t out_item
);

  localparam int Stages = 6;
  localparam int MinP   = MIN_YEAR - 1;
  localparam logic [22:0] DaysBase = 23'(365 * MinP + MinP / 4 - MinP / 100 + MinP / 400);
  localparam logic [13:0] MinYear  = 14'(MIN_YEAR);
  localparam logic [13:0] MaxYear  = 14'(MAX_YEAR);

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [13:0] p;
    logic [7:0]  q100_y;
    logic [7:0]  q100_p;
    logic        date_ok;
    logic [22:0] dby;
    logic [8:0]  doy;
    logic [8:0]  year_mod400;
    logic [22:0] abs_days;
    logic [21:0] epoch;
    logic [5:0]  dsum;
    logic [2:0]  wd;
  } pipe_t;

  pipe_t              pipe      [1:Stages];
  pipe_t              pipe_next [1:Stages];
  logic [1:Stages]    vld;
  logic [1:Stages+1]  rdy;

  // per stage ready: a stage takes new data when empty or when it moves on
  always_comb begin
    rdy[Stages+1] = out_ready;
    for (int k = Stages; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld[Stages];

  // stage logic
  always_comb begin
    logic [27:0] prod_y;
    logic [27:0] prod_p;
    logic        is100;
    logic        leap;
    logic [4:0]  dim;
    logic [13:0] sub400;
    logic [23:0] abs_ext;
    logic [5:0]  dsum;
    logic [3:0]  fold;
    logic [3:0]  rem7;

    // input register
    pipe_next[1]       = pipe[1];
    pipe_next[1].func  = in_func;
    pipe_next[1].day   = in_day;
    pipe_next[1].month = in_month;
    pipe_next[1].year  = in_year;

    // quotients of year and year - 1 by 100
    pipe_next[2]        = pipe[1];
    pipe_next[2].p      = pipe[1].year - 14'd1;
    prod_y              = 28'(pipe[1].year) * 28'(cds_pkg::DIV100_MUL);
    prod_p              = 28'(pipe_next[2].p) * 28'(cds_pkg::DIV100_MUL);
    pipe_next[2].q100_y = prod_y[cds_pkg::DIV100_SHIFT +: 8];
    pipe_next[2].q100_p = prod_p[cds_pkg::DIV100_SHIFT +: 8];

    // leap rule, range check, days before the year, day of the year and year mod 400
    pipe_next[3] = pipe[2];
    is100 = pipe[2].q100_y != pipe[2].q100_p;
    leap  = (pipe[2].year[1:0] == 2'd0 && !is100) || (is100 && pipe[2].q100_y[1:0] == 2'd0);
    dim   = cds_pkg::month_len(pipe[2].month)
            + 5'(leap && pipe[2].month == cds_pkg::MONTH_FEB);
    pipe_next[3].date_ok = pipe[2].year >= MinYear && pipe[2].year <= MaxYear
                           && pipe[2].month >= cds_pkg::MONTH_JAN
                           && pipe[2].month <= cds_pkg::MONTH_DEC
                           && pipe[2].day != 5'd0 && pipe[2].day <= dim;
    pipe_next[3].dby = 23'(pipe[2].p) * 23'd365 + 23'(pipe[2].p[13:2])
                       - 23'(pipe[2].q100_p) + 23'(pipe[2].q100_p[7:2]);
    pipe_next[3].doy = cds_pkg::cum_days(pipe[2].month)
                       + 9'(leap && pipe[2].month > cds_pkg::MONTH_FEB) + 9'(pipe[2].day);
    sub400 = 14'(pipe[2].q100_y[7:2]) * 14'd400;
    pipe_next[3].year_mod400 = 9'(pipe[2].year - sub400);

    // absolute day count from the first day of year 1 and the epoch day number
    pipe_next[4]          = pipe[3];
    pipe_next[4].abs_days = pipe[3].dby + 23'(pipe[3].doy);
    pipe_next[4].epoch    = 22'(pipe[3].dby - DaysBase + 23'(pipe[3].doy));

    // mod 7 by summing octal digits, since 8 is 1 mod 7
    pipe_next[5] = pipe[4];
    abs_ext = {1'b0, pipe[4].abs_days};
    dsum = 6'd0;
    for (int i = 0; i < 8; i++) begin
      dsum = dsum + 6'(abs_ext[3*i +: 3]);
    end
    pipe_next[5].dsum = dsum;

    // final fold; year 1 day 1 was a monday, so remainder 0 is sunday
    pipe_next[6] = pipe[5];
    fold = 4'(pipe[5].dsum[5:3]) + 4'(pipe[5].dsum[2:0]);
    rem7 = (fold >= 4'd7) ? fold - 4'd7 : fold;
    pipe_next[6].wd = (rem7 == 4'd0) ? cds_pkg::WD_SUN : 3'(rem7);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= Stages; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int k = 1; k <= Stages; k++) begin
      if (rdy[k]) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  // hand-off to the state stage
  always_comb begin
    out_item.func        = pipe[Stages].func;
    out_item.date_ok     = pipe[Stages].date_ok;
    out_item.day         = pipe[Stages].day;
    out_item.month       = pipe[Stages].month;
    out_item.year        = pipe[Stages].year;
    out_item.year_mod400 = pipe[Stages].year_mod400;
    out_item.epoch       = pipe[Stages].epoch;
    out_item.wd          = pipe[Stages].wd;
  end

endmodule

// ===== hdl/cds_date_state.sv =====
`timescale 1ns / 1ps

// holds the current date and applies one command per cycle while its result is taken;
// the state registers double as the result register, with error and valid beside them
module cds_date_state #(
  parameter int MIN_YEAR = 1800,
  parameter int MAX_YEAR = 9999
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  cds_pkg::load_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          cur_day,
  output logic [3:0]          cur_month,
  output logic [13:0]         cur_year,
  output logic [2:0]          weekday,
  output logic [21:0]         day_count,
  output logic                error
);

  `include "calendar_date_stepper_assert.svh"

  localparam int MinP     = MIN_YEAR - 1;
  localparam int WdAbs    = 365 * MinP + MinP / 4 - MinP / 100 + MinP / 400 + 1;
  localparam int WdRem    = WdAbs % 7;
  localparam logic [2:0]  ResetWd   = 3'((WdRem == 0) ? 7 : WdRem);
  localparam logic [8:0]  ResetYm   = 9'(MIN_YEAR % 400);
  localparam logic [13:0] MinYear   = 14'(MIN_YEAR);
  localparam logic [13:0] MaxYear   = 14'(MAX_YEAR);
  localparam logic [8:0]  YmLast    = 9'd399;

  logic [4:0]  day,   day_next;
  logic [3:0]  month, month_next;
  logic [13:0] year,  year_next;
  logic [8:0]  ymod,  ymod_next;
  logic [21:0] epoch, epoch_next;
  logic [2:0]  wd,    wd_next;
  logic        err,   err_next;
  logic        accept;
  logic        leap;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_prev;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // leap flag of the stored year from its low bits and its place in the 400 year cycle
  assign leap = year[1:0] == 2'd0 && ymod != 9'd100 && ymod != 9'd200 && ymod != 9'd300;
  assign dim_cur  = cds_pkg::month_len(month) + 5'(leap && month == cds_pkg::MONTH_FEB);
  assign dim_prev = cds_pkg::month_len(month - 4'd1)
                    + 5'(leap && month == cds_pkg::MONTH_FEB + 4'd1);

  // command decode
  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    ymod_next  = ymod;
    epoch_next = epoch;
    wd_next    = wd;
    err_next   = 1'b0;
    unique case (in_item.func)
      cds_pkg::FUNC_LOAD: begin
        if (in_item.date_ok) begin
          day_next   = in_item.day;
          month_next = in_item.month;
          year_next  = in_item.year;
          ymod_next  = in_item.year_mod400;
          epoch_next = in_item.epoch;
          wd_next    = in_item.wd;
        end else begin
          err_next = 1'b1;
        end
      end
      cds_pkg::FUNC_NEXT: begin
        if (day == dim_cur && month == cds_pkg::MONTH_DEC && year == MaxYear) begin
          err_next = 1'b1;
        end else begin
          epoch_next = epoch + 22'd1;
          wd_next    = (wd >= cds_pkg::WD_SUN) ? cds_pkg::WD_MON : wd + 3'd1;
          if (day < dim_cur) begin
            day_next = day + 5'd1;
          end else if (month < cds_pkg::MONTH_DEC) begin
            day_next   = 5'd1;
            month_next = month + 4'd1;
          end else begin
            day_next   = 5'd1;
            month_next = cds_pkg::MONTH_JAN;
            year_next  = year + 14'd1;
            ymod_next  = (ymod == YmLast) ? 9'd0 : ymod + 9'd1;
          end
        end
      end
      cds_pkg::FUNC_PREV: begin
        if (day == 5'd1 && month == cds_pkg::MONTH_JAN && year == MinYear) begin
          err_next = 1'b1;
        end else begin
          epoch_next = epoch - 22'd1;
          wd_next    = (wd <= cds_pkg::WD_MON) ? cds_pkg::WD_SUN : wd - 3'd1;
          if (day > 5'd1) begin
            day_next = day - 5'd1;
          end else if (month > cds_pkg::MONTH_JAN) begin
            month_next = month - 4'd1;
            day_next   = dim_prev;
          end else begin
            month_next = cds_pkg::MONTH_DEC;
            day_next   = 5'd31;
            year_next  = year - 14'd1;
            ymod_next  = (ymod == 9'd0) ? YmLast : ymod - 9'd1;
          end
        end
      end
      cds_pkg::FUNC_NONE: begin
        err_next = 1'b1;
      end
    endcase
  end

  // date state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      day       <= 5'd1;
      month     <= cds_pkg::MONTH_JAN;
      year      <= MinYear;
      ymod      <= ResetYm;
      epoch     <= 22'd1;
      wd        <= ResetWd;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        day   <= day_next;
        month <= month_next;
        year  <= year_next;
        ymod  <= ymod_next;
        epoch <= epoch_next;
        wd    <= wd_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // error flag of the held result
  always_ff @(posedge clk) begin
    if (accept) begin
      err <= err_next;
    end
  end

  assign cur_day   = day;
  assign cur_month = month;
  assign cur_year  = year;
  assign weekday   = wd;
  assign day_count = epoch;
  assign error     = err;

  // checks
  `CDS_ASSERT_IMPL(a_wd_nonzero, out_valid, wd != 3'd0)
  `CDS_ASSERT_NEXT(a_next_counts, accept && in_item.func == cds_pkg::FUNC_NEXT, err || (epoch == $past(epoch) + 22'd1))
  `CDS_ASSERT_NEXT(a_err_keeps, accept, !err || ($stable(day) && $stable(year) && $stable(epoch)))
  `CDS_ASSERT_NEXT(a_load_takes, accept && in_item.func == cds_pkg::FUNC_LOAD && in_item.date_ok, !err && epoch == $past(in_item.epoch) && day == $past(in_item.day))

endmodule

// ===== hdl/calendar_date_stepper.sv =====
`timescale 1ns / 1ps

// channel   dir  tdata fields (low bit up)                                  tuser
// s_axis    in   load_day[4:0] load_month[8:5] load_year[22:9] pad[23]     func[1:0]
// m_axis    out  cur_day[4:0] cur_month[8:5] cur_year[22:9]                error[0]
//                weekday[25:23] day_count[47:26]
//
// one item per cycle sustained while m_tready stays high; each item passes through six
// decode stages for load checking and day number, then the date register
// rst clears all valids and sets the date to 1 January MIN_YEAR, day number 1
// m_tready low holds the result; backpressure walks back stage by stage, so empty
// stages still fill and s_tready falls only once the whole pipeline is full
module calendar_date_stepper #(
  parameter int MIN_YEAR = 1800,
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // load_day, load_month, load_year, zero pad
  input  logic [1:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // cur_day, cur_month, cur_year, weekday, day_count
  output logic        m_tuser    // error
);

  cds_pkg::load_item_t item;
  logic                item_valid;
  logic                item_ready;
  logic [4:0]          cur_day;
  logic [3:0]          cur_month;
  logic [13:0]         cur_year;
  logic [2:0]          weekday;
  logic [21:0]         day_count;

  // load check and date decode pipeline
  cds_load_calc #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_load_calc (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_day    (s_tdata[4:0]),
    .in_month  (s_tdata[8:5]),
    .in_year   (s_tdata[22:9]),
    .out_valid (item_valid),
    .out_ready (item_ready),
    .out_item  (item)
  );

  // stored date and result register
  cds_date_state #(
    .MIN_YEAR (MIN_YEAR),
    .MAX_YEAR (MAX_YEAR)
  ) u_date_state (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (item_ready),
    .in_item   (item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cur_day   (cur_day),
    .cur_month (cur_month),
    .cur_year  (cur_year),
    .weekday   (weekday),
    .day_count (day_count),
    .error     (m_tuser)
  );

  // result packing
  assign m_tdata = {day_count, weekday, cur_year, cur_month, cur_day};

endmodule
